[rtl/knnmv_pkg.sv]
// Package for the k-nearest-neighbour vote classifier: constants, item types, state encoding.
package knnmv_pkg;

    localparam int K_MAX                = 16;
    localparam int FEATURE_BITS         = 9;
    localparam int WEATHER_CLASSES      = 6;
    localparam int ILLUMINATION_CLASSES = 9;
    localparam int ENVIRONMENT_CLASSES  = 6;

    localparam int WL_W  = 3;
    localparam int IL_W  = 4;
    localparam int EL_W  = 3;
    localparam int K_W   = 5;

    localparam int ADDR_W = $clog2(K_MAX);
    localparam int CNT_W  = $clog2(K_MAX + 1);
    localparam int SQ_W   = 2 * FEATURE_BITS;
    localparam int DIST_W = 2 * FEATURE_BITS + 2;

    localparam int CLASS_SPAN_WI = (WEATHER_CLASSES > ILLUMINATION_CLASSES) ?
                                   WEATHER_CLASSES : ILLUMINATION_CLASSES;
    localparam int CLASS_SPAN    = (CLASS_SPAN_WI > ENVIRONMENT_CLASSES) ?
                                   CLASS_SPAN_WI : ENVIRONMENT_CLASSES;
    localparam int PICK_W        = $clog2(CLASS_SPAN);

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_REF   = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [FEATURE_BITS-1:0] hue;
        logic [FEATURE_BITS-1:0] chroma;
        logic [FEATURE_BITS-1:0] contrast;
        logic [FEATURE_BITS-1:0] intensity;
        logic [WL_W-1:0]         weather_label;
        logic [IL_W-1:0]         illumination_label;
        logic [EL_W-1:0]         environment_label;
        logic                    is_query_itself;
        logic                    last_reference;
    } t_in_item;

    typedef struct packed {
        logic [WL_W-1:0]  weather_vote;
        logic [IL_W-1:0]  illumination_vote;
        logic [EL_W-1:0]  environment_vote;
        logic [CNT_W-1:0] neighbors_found;
    } t_out_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [WL_W-1:0]   weather;
        logic [IL_W-1:0]   illumination;
        logic [EL_W-1:0]   environment;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_DECIDE,
        S_SCAN,
        S_WRITE,
        S_COUNT,
        S_PICK,
        S_EMIT
    } t_state;

endpackage

[rtl/knn_majority_vote_classifier_top.sv]
// Top level of the k-nearest-neighbour majority-vote classifier.
// Query item: taken while idle. Reference item: square, sum and decide steps, then a write
// into the next free slot, or, once the list is full, a walk over the kept list through the
// one RAM read port and a write over the largest kept distance if the new one is smaller.
// Last reference adds a count walk, CLASS_SPAN pick steps and a load of the output register.
// One item at a time; stall is high while an item is at work or a result awaits loading.
// Synchronous active-low reset: control idle, k = 1, query features zero, list empty.
// List RAM contents are undefined until written; only filled entries are ever read.
module knn_majority_vote_classifier_top import knnmv_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  t_in_item       i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output t_out_item      o_out_data,
    input  logic           i_cfg_we,
    input  logic [K_W-1:0] i_cfg_wdata
);

    t_state                  r_state, n_state;
    logic [K_W-1:0]          r_k;
    logic [CNT_W-1:0]        k_eff;
    logic [FEATURE_BITS-1:0] r_q_hue, r_q_chroma, r_q_contrast, r_q_intensity;
    t_in_item                r_item;
    logic [SQ_W-1:0]         r_sq [4];
    logic [DIST_W-1:0]       r_dist;
    logic [CNT_W-1:0]        r_filled;
    logic [ADDR_W-1:0]       r_slot;
    logic [DIST_W-1:0]       r_max;
    logic [CNT_W-1:0]        r_raddr;
    logic                    r_rvalid;
    logic [ADDR_W-1:0]       r_ridx;
    logic [CNT_W-1:0]        r_cnt_w [2**WL_W];
    logic [CNT_W-1:0]        r_cnt_i [2**IL_W];
    logic [CNT_W-1:0]        r_cnt_e [2**EL_W];
    logic [PICK_W-1:0]       r_ci;
    logic [WL_W-1:0]         r_wpick;
    logic [IL_W-1:0]         r_ipick;
    logic [EL_W-1:0]         r_epick;
    logic [CNT_W-1:0]        r_wbest, r_ibest, r_ebest;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic   in_acc;
    logic   ram_we;
    logic   walk;
    logic   rd_en;
    logic   walk_done;
    logic   out_load;
    t_state ref_end;
    t_entry wentry;
    t_entry rentry;
    logic [ENTRY_W-1:0] rdata;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [FEATURE_BITS-1:0] a,
                                                input logic [FEATURE_BITS-1:0] b);
        logic [FEATURE_BITS-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    always_comb begin
        if (r_k == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(r_k) > K_MAX) begin
            k_eff = CNT_W'(K_MAX);
        end else begin
            k_eff = CNT_W'(r_k);
        end
    end

    assign in_acc  = i_in_valid && !o_in_stall;
    assign ref_end = r_item.last_reference ? S_COUNT : S_IDLE;
    assign rentry  = t_entry'(rdata);

    // control outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        ram_we     = (r_state == S_WRITE);
        walk       = (r_state == S_SCAN) || (r_state == S_COUNT);
        rd_en      = walk && (r_raddr < r_filled);
        walk_done  = walk && (r_raddr == r_filled) && !r_rvalid;
        out_load   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.mode == MODE_REF) begin
                    if (i_in_data.is_query_itself) begin
                        n_state = i_in_data.last_reference ? S_COUNT : S_IDLE;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_DECIDE;
            S_DECIDE: n_state = (r_filled < k_eff) ? S_WRITE : S_SCAN;
            S_SCAN: begin
                if (walk_done) begin
                    n_state = (r_dist < r_max) ? S_WRITE : ref_end;
                end
            end
            S_WRITE:  n_state = ref_end;
            S_COUNT: begin
                if (walk_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (int'(r_ci) == CLASS_SPAN - 1) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= K_W'(1);
            r_q_hue       <= '0;
            r_q_chroma    <= '0;
            r_q_contrast  <= '0;
            r_q_intensity <= '0;
            r_filled      <= '0;
            r_raddr       <= '0;
            r_rvalid      <= 1'b0;
            r_ci          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (in_acc && i_in_data.mode == MODE_QUERY) begin
                r_q_hue       <= i_in_data.hue;
                r_q_chroma    <= i_in_data.chroma;
                r_q_contrast  <= i_in_data.contrast;
                r_q_intensity <= i_in_data.intensity;
                r_filled      <= '0;
            end else if (r_state == S_DECIDE && r_filled < k_eff) begin
                r_filled <= r_filled + CNT_W'(1);
            end
            // list walk address: restarts on every state change
            if (n_state != r_state) begin
                r_raddr  <= '0;
                r_rvalid <= 1'b0;
            end else if (rd_en) begin
                r_raddr  <= r_raddr + CNT_W'(1);
                r_rvalid <= 1'b1;
            end else begin
                r_rvalid <= 1'b0;
            end
            r_ci <= (r_state == S_PICK) ? r_ci + PICK_W'(1) : '0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (rd_en) begin
            r_ridx <= r_raddr[ADDR_W-1:0];
        end
        if (r_state == S_SQUARE) begin
            r_sq[0] <= sq_diff(r_q_hue, r_item.hue);
            r_sq[1] <= sq_diff(r_q_chroma, r_item.chroma);
            r_sq[2] <= sq_diff(r_q_contrast, r_item.contrast);
            r_sq[3] <= sq_diff(r_q_intensity, r_item.intensity);
        end
        if (r_state == S_SUM) begin
            r_dist <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2])
                    + DIST_W'(r_sq[3]);
        end
        if (r_state == S_DECIDE && r_filled < k_eff) begin
            r_slot <= r_filled[ADDR_W-1:0];
        end else if (r_state == S_SCAN && r_rvalid) begin
            // first largest wins: strict compare
            if (r_ridx == '0 || rentry.distance > r_max) begin
                r_max  <= rentry.distance;
                r_slot <= r_ridx;
            end
        end
        if (out_load) begin
            r_out.weather_vote      <= r_wpick;
            r_out.illumination_vote <= r_ipick;
            r_out.environment_vote  <= r_epick;
            r_out.neighbors_found   <= r_filled;
        end
    end

    // label tally and vote pick
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            for (int j = 0; j < 2**WL_W; j++) r_cnt_w[j] <= '0;
            for (int j = 0; j < 2**IL_W; j++) r_cnt_i[j] <= '0;
            for (int j = 0; j < 2**EL_W; j++) r_cnt_e[j] <= '0;
        end else if (r_state == S_COUNT && r_rvalid) begin
            for (int j = 0; j < 2**WL_W; j++) begin
                if (j < WEATHER_CLASSES && rentry.weather == WL_W'(j)) begin
                    r_cnt_w[j] <= r_cnt_w[j] + CNT_W'(1);
                end
            end
            for (int j = 0; j < 2**IL_W; j++) begin
                if (j < ILLUMINATION_CLASSES && rentry.illumination == IL_W'(j)) begin
                    r_cnt_i[j] <= r_cnt_i[j] + CNT_W'(1);
                end
            end
            for (int j = 0; j < 2**EL_W; j++) begin
                if (j < ENVIRONMENT_CLASSES && rentry.environment == EL_W'(j)) begin
                    r_cnt_e[j] <= r_cnt_e[j] + CNT_W'(1);
                end
            end
        end
        // picks hold through the emit state until the output register takes them
        if (r_state == S_IDLE) begin
            r_wpick <= '0;
            r_ipick <= '0;
            r_epick <= '0;
            r_wbest <= '0;
            r_ibest <= '0;
            r_ebest <= '0;
        end else if (r_state == S_PICK) begin
            if (int'(r_ci) < WEATHER_CLASSES && r_cnt_w[r_ci[WL_W-1:0]] > r_wbest) begin
                r_wbest <= r_cnt_w[r_ci[WL_W-1:0]];
                r_wpick <= r_ci[WL_W-1:0];
            end
            if (int'(r_ci) < ILLUMINATION_CLASSES && r_cnt_i[IL_W'(r_ci)] > r_ibest) begin
                r_ibest <= r_cnt_i[IL_W'(r_ci)];
                r_ipick <= IL_W'(r_ci);
            end
            if (int'(r_ci) < ENVIRONMENT_CLASSES && r_cnt_e[r_ci[EL_W-1:0]] > r_ebest) begin
                r_ebest <= r_cnt_e[r_ci[EL_W-1:0]];
                r_epick <= r_ci[EL_W-1:0];
            end
        end
    end

    assign wentry.distance     = r_dist;
    assign wentry.weather      = r_item.weather_label;
    assign wentry.illumination = r_item.illumination_label;
    assign wentry.environment  = r_item.environment_label;

    knnmv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (K_MAX)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wentry),
        .i_raddr (r_raddr[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_filled) <= K_MAX)
        else $error("kept list count beyond capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CNT_W'(r_slot) < r_filled))
        else $error("list write outside kept entries");

    a_query_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.mode == MODE_QUERY) |=> (r_filled == '0))
        else $error("query load did not empty the list");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside vote emission");
`endif

endmodule

[rtl/knnmv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module knnmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[test/knn_majority_vote_classifier_top_test.sv]
// Self-checking testbench for the k-nearest-neighbour majority-vote classifier top level.
`timescale 1ns / 100ps

import knnmv_pkg::*;

class knn_vote_scoreboard;
    logic [FEATURE_BITS-1:0] q_hue, q_chroma, q_contrast, q_intensity;
    logic [DIST_W-1:0]       kept_dist    [K_MAX];
    logic [WL_W-1:0]         kept_weather [K_MAX];
    logic [IL_W-1:0]         kept_illum   [K_MAX];
    logic [EL_W-1:0]         kept_env     [K_MAX];
    int unsigned             kept_count;
    logic [K_W-1:0]          k_setting;
    t_out_item               vote_queue [$];
    int unsigned             mismatches;
    int unsigned             votes_checked;

    function new();
        q_hue = '0;
        q_chroma = '0;
        q_contrast = '0;
        q_intensity = '0;
        kept_count = 0;
        k_setting = K_W'(1);
        mismatches = 0;
        votes_checked = 0;
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function void set_k(logic [K_W-1:0] value);
        k_setting = value;
    endfunction

    function logic [DIST_W-1:0] sq_diff(logic [FEATURE_BITS-1:0] a, logic [FEATURE_BITS-1:0] b);
        logic [FEATURE_BITS-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return DIST_W'(d) * DIST_W'(d);
    endfunction

    // lowest class wins a tie; labels past the class count cast no vote
    function int unsigned majority(int unsigned labels [K_MAX], int unsigned classes);
        int unsigned counts [16];
        int unsigned pick;
        foreach (counts[i]) counts[i] = 0;
        pick = 0;
        for (int unsigned i = 0; i < kept_count && i < K_MAX; i++)
            if (labels[i] < classes) counts[labels[i]]++;
        for (int unsigned i = 0; i < classes; i++)
            if (counts[pick] < counts[i]) pick = i;
        return pick;
    endfunction

    function void note_input(t_in_item item);
        int unsigned       k_eff, slot, top_idx;
        logic [DIST_W-1:0] ref_dist, top_dist;
        int unsigned       lab_w [K_MAX];
        int unsigned       lab_i [K_MAX];
        int unsigned       lab_e [K_MAX];
        t_out_item         vote;
        k_eff = (k_setting < 1) ? 1 : (k_setting > K_MAX) ? K_MAX : k_setting;
        if (item.mode == MODE_QUERY) begin
            q_hue = item.hue;
            q_chroma = item.chroma;
            q_contrast = item.contrast;
            q_intensity = item.intensity;
            kept_count = 0;
            return;
        end
        if (!item.is_query_itself) begin
            ref_dist = sq_diff(q_hue, item.hue) + sq_diff(q_chroma, item.chroma)
                     + sq_diff(q_contrast, item.contrast)
                     + sq_diff(q_intensity, item.intensity);
            slot = K_MAX;
            if (kept_count < k_eff) begin
                slot = kept_count;
                kept_count++;
            end else if (kept_count > 0) begin
                top_idx = 0;
                top_dist = kept_dist[0];
                for (int unsigned i = 1; i < kept_count; i++) begin
                    if (kept_dist[i] > top_dist) begin
                        top_dist = kept_dist[i];
                        top_idx = i;
                    end
                end
                if (ref_dist < top_dist) slot = top_idx;
            end
            if (slot < K_MAX) begin
                kept_dist[slot] = ref_dist;
                kept_weather[slot] = item.weather_label;
                kept_illum[slot] = item.illumination_label;
                kept_env[slot] = item.environment_label;
            end
        end
        if (!item.last_reference) return;
        for (int unsigned i = 0; i < K_MAX; i++) begin
            lab_w[i] = (i < kept_count) ? kept_weather[i] : 0;
            lab_i[i] = (i < kept_count) ? kept_illum[i] : 0;
            lab_e[i] = (i < kept_count) ? kept_env[i] : 0;
        end
        vote.weather_vote = WL_W'(majority(lab_w, WEATHER_CLASSES));
        vote.illumination_vote = IL_W'(majority(lab_i, ILLUMINATION_CLASSES));
        vote.environment_vote = EL_W'(majority(lab_e, ENVIRONMENT_CLASSES));
        vote.neighbors_found = CNT_W'(kept_count);
        vote_queue.insert(vote_queue.size(), vote);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(t_out_item got);
        t_out_item want;
        if (vote_queue.size() == 0) begin
            report("vote item with none expected");
            return;
        end
        want = vote_queue.pop_front();
        votes_checked++;
        check_field("weather_vote", 8'(got.weather_vote), 8'(want.weather_vote));
        check_field("illumination_vote", 8'(got.illumination_vote),
                    8'(want.illumination_vote));
        check_field("environment_vote", 8'(got.environment_vote), 8'(want.environment_vote));
        check_field("neighbors_found", 8'(got.neighbors_found), 8'(want.neighbors_found));
    endtask
endclass

module knn_majority_vote_classifier_top_test;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 850;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    t_in_item       in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    t_out_item      out_data;
    logic           cfg_we    = 1'b0;
    logic [K_W-1:0] cfg_wdata = '0;

    knn_vote_scoreboard sb;
    int unsigned idle_in_pct  = 0;
    int unsigned idle_out_pct = 0;
    int unsigned items_sent   = 0;
    int unsigned k_writes     = 0;
    int unsigned cycle_count  = 0;

    knn_majority_vote_classifier_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < idle_out_pct);
    end

    task send_item(t_in_item item);
        while ($urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(item);
        items_sent++;
    endtask

    task send_query(int h, int c, int t, int v, bit last);
        t_in_item item;
        item = '0;
        item.mode = MODE_QUERY;
        item.hue = FEATURE_BITS'(h);
        item.chroma = FEATURE_BITS'(c);
        item.contrast = FEATURE_BITS'(t);
        item.intensity = FEATURE_BITS'(v);
        item.last_reference = last;
        send_item(item);
    endtask

    task send_ref(int h, int c, int t, int v, int wl, int il, int el, bit self_ref, bit last);
        t_in_item item;
        item.mode = MODE_REF;
        item.hue = FEATURE_BITS'(h);
        item.chroma = FEATURE_BITS'(c);
        item.contrast = FEATURE_BITS'(t);
        item.intensity = FEATURE_BITS'(v);
        item.weather_label = WL_W'(wl);
        item.illumination_label = IL_W'(il);
        item.environment_label = EL_W'(el);
        item.is_query_itself = self_ref;
        item.last_reference = last;
        send_item(item);
    endtask

    // block must be idle: no vote pending and time for a silent item to finish
    task wait_drain();
        in_valid <= 1'b0;
        while (sb.vote_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_k(logic [K_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_k(value);
        k_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function logic [K_W-1:0] pick_k();
        case ($urandom_range(9))
            0: return K_W'(0);
            1: return K_W'(1);
            2: return K_W'(16);
            3: return K_W'(31);
            4: return K_W'(17);
            default: return K_W'($urandom_range(2, 8));
        endcase
    endfunction

    function logic [FEATURE_BITS-1:0] pick_feature(int unsigned style,
                                                   logic [FEATURE_BITS-1:0] centre);
        case (style)
            0: return FEATURE_BITS'($urandom);
            1: return centre + FEATURE_BITS'($urandom_range(0, 15)) - FEATURE_BITS'(8);
            2: return $urandom_range(1) ? '1 : '0;
            default: return centre + FEATURE_BITS'($urandom_range(0, 2));
        endcase
    endfunction

    function logic [3:0] pick_label(int unsigned span, int unsigned classes, int unsigned bits);
        case (span)
            0: return 4'($urandom_range(0, 2));
            1: return 4'($urandom_range(0, classes - 1));
            default: return 4'($urandom_range(0, (1 << bits) - 1));
        endcase
    endfunction

    function t_in_item noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    task run_set(bit fresh_query);
        t_in_item                item;
        int unsigned             n_refs, style, span;
        bit                      broken;
        logic [FEATURE_BITS-1:0] qh, qc, qt, qv;
        n_refs = $urandom_range(1, 20);
        style = $urandom_range(3);
        span = $urandom_range(2);
        broken = ($urandom_range(9) == 0);
        qh = FEATURE_BITS'($urandom);
        qc = FEATURE_BITS'($urandom);
        qt = FEATURE_BITS'($urandom);
        qv = FEATURE_BITS'($urandom);
        if (fresh_query) send_query(int'(qh), int'(qc), int'(qt), int'(qv),
                                    $urandom_range(7) == 0);
        for (int unsigned r = 0; r < n_refs; r++) begin
            item.mode = MODE_REF;
            item.hue = pick_feature(style, qh);
            item.chroma = pick_feature(style, qc);
            item.contrast = pick_feature(style, qt);
            item.intensity = pick_feature(style, qv);
            item.weather_label = WL_W'(pick_label(span, WEATHER_CLASSES, WL_W));
            item.illumination_label = IL_W'(pick_label(span, ILLUMINATION_CLASSES, IL_W));
            item.environment_label = EL_W'(pick_label(span, ENVIRONMENT_CLASSES, EL_W));
            item.is_query_itself = ($urandom_range(7) == 0);
            item.last_reference = (r == n_refs - 1) && !broken;
            send_item(item);
        end
    endtask

    initial begin
        int unsigned directed_items, phase_start, roll;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reference before any query load, k from reset
        send_ref(5, 0, 0, 0, 1, 2, 3, 1'b0, 1'b1);
        // last flag on a query load is ignored; skipped last gives an empty vote
        send_query(511, 511, 511, 511, 1'b1);
        send_ref(0, 0, 0, 0, 7, 15, 7, 1'b1, 1'b1);
        wait_drain();
        write_k(K_W'(16));
        send_query(0, 0, 0, 0, 1'b0);
        send_ref(511, 511, 511, 511, 7, 15, 7, 1'b0, 1'b0);
        send_ref(0, 0, 0, 0, 5, 8, 5, 1'b0, 1'b0);
        send_ref(1, 1, 1, 1, 5, 8, 5, 1'b0, 1'b0);
        send_ref(2, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
        send_ref(0, 2, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        // k lowered below the list size, list carries on without a query load
        wait_drain();
        write_k(K_W'(2));
        send_ref(3, 0, 0, 0, 1, 1, 1, 1'b0, 1'b0);
        send_ref(511, 0, 0, 0, 2, 2, 2, 1'b0, 1'b0);
        send_ref(0, 0, 0, 0, 3, 3, 3, 1'b1, 1'b1);
        // k of zero acts as one; equal distance does not replace
        wait_drain();
        write_k(K_W'(0));
        send_query(100, 200, 300, 400, 1'b0);
        send_ref(100, 200, 300, 400, 3, 4, 3, 1'b0, 1'b0);
        send_ref(100, 200, 300, 401, 4, 5, 4, 1'b0, 1'b0);
        send_ref(100, 200, 300, 400, 2, 2, 2, 1'b0, 1'b1);
        // k above range is clamped
        wait_drain();
        write_k(K_W'(31));
        send_query(511, 0, 511, 0, 1'b0);
        send_ref(510, 1, 509, 2, 4, 6, 1, 1'b0, 1'b0);
        send_ref(0, 511, 0, 511, 4, 6, 1, 1'b0, 1'b0);
        send_ref(511, 0, 511, 0, 5, 7, 2, 1'b0, 1'b1);
        wait_drain();
        directed_items = items_sent;

        for (int phase = 0; phase < 3; phase++) begin
            idle_in_pct = (phase == 0) ? 32 : (phase == 1) ? 49 : 0;
            idle_out_pct = (phase == 0) ? 49 : (phase == 1) ? 32 : 0;
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / 3) begin
                if ($urandom_range(3) == 0) begin
                    wait_drain();
                    write_k(pick_k());
                end
                roll = $urandom_range(19);
                if (roll < 2) send_item(noise_item());
                else run_set(roll >= 4);
            end
            wait_drain();
        end

        $display("covered %0d items (%0d directed) over %0d neighbour-count writes",
                 items_sent, directed_items, k_writes);
        $display("%0d votes checked under three idle profiles, %0d mismatches",
                 sb.votes_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/knnmv_pkg.sv
rtl/knnmv_ram.sv
rtl/knn_majority_vote_classifier_top.sv
test/knn_majority_vote_classifier_top_test.sv
